/* hw/rtl/btt_pkg.sv */
// Shared types and constants for the brace template tokenizer.
package btt_pkg;

    // Path length bound and derived position widths
    localparam int MAX_PATH_LEN = 1024;
    localparam int POS_W        = $clog2(MAX_PATH_LEN);
    localparam int LEN_W        = POS_W + 1;

    // Beat queue between the front and back halves
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_HASH  = 8'h23;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    // Byte classes produced by the front half
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_COLON,
        CLS_HASH,
        CLS_DOT,
        CLS_END
    } cls_t;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_OUT,
        MODE_POPEN,
        MODE_PCLOSE,
        MODE_NAME,
        MODE_SPEC
    } mode_t;

    // Token kinds
    typedef enum logic [2:0] {
        KIND_VAR       = 3'd0,
        KIND_ESC_OPEN  = 3'd1,
        KIND_ESC_CLOSE = 3'd2,
        KIND_SYNTAX    = 3'd3,
        KIND_FMT_ERR   = 3'd4,
        KIND_LONE      = 3'd5,
        KIND_END       = 3'd6
    } kind_t;

    // Format spec classes
    typedef enum logic [1:0] {
        FMT_NONE  = 2'd0,
        FMT_INT   = 2'd1,
        FMT_FLOAT = 2'd2
    } fmt_t;

    // Dot counter codes (saturates at more than one)
    localparam logic [1:0] DOTS_NONE = 2'd0;
    localparam logic [1:0] DOTS_ONE  = 2'd1;
    localparam logic [1:0] DOTS_MANY = 2'd2;

    // Classified byte carried through the queue
    typedef struct packed {
        cls_t             cls;
        logic [POS_W-1:0] pos;
        logic             last;
    } beat_t;

    // One result token
    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] range_start;
        logic [LEN_W-1:0] range_end;
        logic [LEN_W-1:0] name_start;
        logic [LEN_W-1:0] name_end;
        fmt_t             format_kind;
        logic [7:0]       int_digits;
        logic [7:0]       frac_digits;
        logic             end_of_path;
    } tok_t;

endpackage

/* hw/rtl/btt_fifo.sv */
// Small beat queue between the classifying front and the parsing back.
module btt_fifo
    import btt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t push_beat,
    output logic  full,
    input  logic  pop,
    output beat_t pop_beat,
    output logic  empty
);

    beat_t           slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;

    assign full     = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_beat = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

/* hw/rtl/btt_front.sv */
// Front half: accepts path bytes, tracks position and classifies each byte.
module btt_front
    import btt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] ch,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       q_full,
    output logic       push,
    output beat_t      push_beat
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             at_last;
    cls_t             cls;

    assign byte_stall = q_full;
    assign push       = byte_valid && !q_full;
    assign at_last    = (pos_reg == POS_W'(MAX_PATH_LEN - 1));

    // Byte classification
    always_comb
    begin
        case (ch)
            CH_NUL:   cls = CLS_END;
            CH_OPEN:  cls = CLS_OPEN;
            CH_CLOSE: cls = CLS_CLOSE;
            CH_COLON: cls = CLS_COLON;
            CH_HASH:  cls = CLS_HASH;
            CH_DOT:   cls = CLS_DOT;
            default:  cls = CLS_OTHER;
        endcase
    end

    always_comb
    begin
        push_beat.cls  = cls;
        push_beat.pos  = pos_reg;
        push_beat.last = at_last && (cls != CLS_END);
    end

    // Position restarts after a terminator or the length bound
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (cls == CLS_END || at_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* hw/rtl/btt_back.sv */
// Back half: brace parser state machine and token output stage.
module btt_back
    import btt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_empty,
    input  beat_t beat,
    output logic  pop,
    output logic  tok_valid,
    input  logic  tok_stall,
    output tok_t  tok
);

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [POS_W-1:0] open_pos_reg;
    logic [POS_W-1:0] open_pos_next;
    logic [POS_W-1:0] colon_pos_reg;
    logic [POS_W-1:0] colon_pos_next;
    logic [7:0]       hb_reg;
    logic [7:0]       hb_next;
    logic [7:0]       ha_reg;
    logic [7:0]       ha_next;
    logic [1:0]       dots_reg;
    logic [1:0]       dots_next;
    logic             bad_reg;
    logic             bad_next;

    tok_t             tok_a;
    logic             tok_a_valid;
    tok_t             tok_b;
    logic             do_end;
    logic             done;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] open_ext;
    logic [LEN_W-1:0] end_len;
    logic             spec_err;

    logic             out_valid_reg;
    logic             out_valid_next;
    tok_t             out_tok_reg;
    tok_t             out_tok_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    tok_t             pend_tok_reg;
    tok_t             pend_tok_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !tok_stall;
    assign pop       = !q_empty && !pend_valid_reg && out_free;
    assign tok_valid = out_valid_reg;
    assign tok       = out_tok_reg;

    // Parser next state and tokens for the beat at the queue head
    always_comb
    begin
        mode_next      = mode_reg;
        open_pos_next  = open_pos_reg;
        colon_pos_next = colon_pos_reg;
        hb_next        = hb_reg;
        ha_next        = ha_reg;
        dots_next      = dots_reg;
        bad_next       = bad_reg;
        tok_a          = '0;
        tok_a_valid    = 1'b0;
        tok_b          = '0;
        do_end         = 1'b0;
        done           = 1'b0;
        end_len        = '0;
        spec_err       = 1'b0;
        pos_ext        = {1'b0, beat.pos};
        open_ext       = {1'b0, open_pos_reg};

        if (beat.cls == CLS_END)
        begin
            do_end  = 1'b1;
            end_len = pos_ext;
        end
        else
        begin
            // Resolve a pending brace first
            case (mode_reg)
                MODE_POPEN:
                begin
                    if (beat.cls == CLS_OPEN)
                    begin
                        tok_a.kind        = KIND_ESC_OPEN;
                        tok_a.range_start = open_pos_reg;
                        tok_a.range_end   = open_ext + LEN_W'(2);
                        tok_a_valid       = 1'b1;
                        mode_next         = MODE_OUT;
                        done              = 1'b1;
                    end
                    else
                    begin
                        mode_next      = MODE_NAME;
                        colon_pos_next = '0;
                        hb_next        = '0;
                        ha_next        = '0;
                        dots_next      = DOTS_NONE;
                        bad_next       = 1'b0;
                    end
                end
                MODE_PCLOSE:
                begin
                    tok_a.range_start = open_pos_reg;
                    tok_a_valid       = 1'b1;
                    mode_next         = MODE_OUT;
                    if (beat.cls == CLS_CLOSE)
                    begin
                        tok_a.kind      = KIND_ESC_CLOSE;
                        tok_a.range_end = open_ext + LEN_W'(2);
                        done            = 1'b1;
                    end
                    else
                    begin
                        tok_a.kind      = KIND_LONE;
                        tok_a.range_end = open_ext + LEN_W'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (!done)
            begin
                if (mode_next inside {MODE_NAME, MODE_SPEC})
                begin
                    case (beat.cls)
                        CLS_OPEN:
                        begin
                            // nested open brace: error, brace becomes pending
                            tok_a.kind        = KIND_SYNTAX;
                            tok_a.range_start = open_pos_next;
                            tok_a.range_end   = pos_ext;
                            tok_a_valid       = 1'b1;
                            mode_next         = MODE_POPEN;
                            open_pos_next     = beat.pos;
                        end
                        CLS_CLOSE:
                        begin
                            spec_err = bad_next || (dots_next == DOTS_MANY) ||
                                       (dots_next == DOTS_NONE && hb_next == '0) ||
                                       (dots_next == DOTS_ONE && ha_next == '0);
                            tok_a.range_start = open_pos_next;
                            tok_a.range_end   = pos_ext + LEN_W'(1);
                            tok_a_valid       = 1'b1;
                            if (colon_pos_next == '0)
                            begin
                                tok_a.kind       = KIND_VAR;
                                tok_a.name_start = {1'b0, open_pos_next} + LEN_W'(1);
                                tok_a.name_end   = pos_ext;
                            end
                            else if (spec_err)
                            begin
                                tok_a.kind = KIND_FMT_ERR;
                            end
                            else
                            begin
                                tok_a.kind       = KIND_VAR;
                                tok_a.name_start = {1'b0, open_pos_next} + LEN_W'(1);
                                tok_a.name_end   = {1'b0, colon_pos_next};
                                tok_a.int_digits = hb_next;
                                if (dots_next == DOTS_NONE)
                                begin
                                    tok_a.format_kind = FMT_INT;
                                end
                                else
                                begin
                                    tok_a.format_kind = FMT_FLOAT;
                                    tok_a.frac_digits = ha_next;
                                end
                            end
                            mode_next = MODE_OUT;
                        end
                        CLS_COLON:
                        begin
                            if (mode_next == MODE_NAME)
                            begin
                                mode_next      = MODE_SPEC;
                                colon_pos_next = beat.pos;
                            end
                            else
                            begin
                                bad_next = 1'b1;
                            end
                        end
                        CLS_HASH:
                        begin
                            if (mode_next == MODE_SPEC)
                            begin
                                if (dots_next == DOTS_NONE)
                                begin
                                    if (hb_next != CNT_MAX)
                                    begin
                                        hb_next = hb_next + 8'd1;
                                    end
                                end
                                else if (ha_next != CNT_MAX)
                                begin
                                    ha_next = ha_next + 8'd1;
                                end
                            end
                        end
                        CLS_DOT:
                        begin
                            if (mode_next == MODE_SPEC && dots_next != DOTS_MANY)
                            begin
                                dots_next = dots_next + 2'd1;
                            end
                        end
                        default:
                        begin
                            if (mode_next == MODE_SPEC)
                            begin
                                bad_next = 1'b1;
                            end
                        end
                    endcase
                end
                else
                begin
                    // Outside a variable
                    mode_next = MODE_OUT;
                    if (beat.cls == CLS_OPEN)
                    begin
                        mode_next     = MODE_POPEN;
                        open_pos_next = beat.pos;
                    end
                    else if (beat.cls == CLS_CLOSE)
                    begin
                        mode_next     = MODE_PCLOSE;
                        open_pos_next = beat.pos;
                    end
                end
            end

            do_end  = beat.last;
            end_len = LEN_W'(MAX_PATH_LEN);
        end

        // End of path: report what is still open, or an end token if nothing is, then clear
        if (do_end)
        begin
            if (mode_next inside {MODE_POPEN, MODE_NAME, MODE_SPEC})
            begin
                tok_b.kind        = KIND_SYNTAX;
                tok_b.range_start = open_pos_next;
                tok_b.range_end   = end_len;
            end
            else if (mode_next == MODE_PCLOSE)
            begin
                tok_b.kind        = KIND_LONE;
                tok_b.range_start = open_pos_next;
                tok_b.range_end   = {1'b0, open_pos_next} + LEN_W'(1);
            end
            else
            begin
                tok_b.kind = KIND_END;
            end
            tok_b.end_of_path = 1'b1;
            mode_next         = MODE_OUT;
            open_pos_next     = '0;
            colon_pos_next    = '0;
            hb_next           = '0;
            ha_next           = '0;
            dots_next         = DOTS_NONE;
            bad_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OUT;
            open_pos_reg  <= '0;
            colon_pos_reg <= '0;
            hb_reg        <= '0;
            ha_reg        <= '0;
            dots_reg      <= DOTS_NONE;
            bad_reg       <= 1'b0;
        end
        else if (pop)
        begin
            mode_reg      <= mode_next;
            open_pos_reg  <= open_pos_next;
            colon_pos_reg <= colon_pos_next;
            hb_reg        <= hb_next;
            ha_reg        <= ha_next;
            dots_reg      <= dots_next;
            bad_reg       <= bad_next;
        end
    end

    // Output register plus one held second token
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_tok_next    = out_tok_reg;
        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_tok_next    = pend_tok_reg;
                pend_valid_next = 1'b0;
            end
            else if (pop)
            begin
                out_valid_next  = tok_a_valid || do_end;
                out_tok_next    = tok_a_valid ? tok_a : tok_b;
                pend_valid_next = tok_a_valid && do_end;
                pend_tok_next   = tok_b;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        pend_tok_reg <= pend_tok_next;
    end

endmodule

/* hw/rtl/brace_template_tokenizer_core.sv */
// Bytes go through the beat queue to the parser, whose tokens are registered before output.
// Throughput: one byte per cycle while byte_stall is low; a byte at the last path position can
// yield two tokens, which leave the output register in turn while the queue absorbs the input.
// The four-beat queue between the classifier and the parser sets how far the sides decouple.
// Reset (rst_n low, asynchronous) empties the queue and output, and returns the parser
// to outside mode at position 0.
module brace_template_tokenizer_core
    import btt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  logic [7:0]       ch,
    output logic             tok_valid,
    input  logic             tok_stall,
    output logic [2:0]       kind,
    output logic [POS_W-1:0] range_start,
    output logic [LEN_W-1:0] range_end,
    output logic [LEN_W-1:0] name_start,
    output logic [LEN_W-1:0] name_end,
    output logic [1:0]       format_kind,
    output logic [7:0]       int_digits,
    output logic [7:0]       frac_digits,
    output logic             end_of_path
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    beat_t push_beat;
    beat_t pop_beat;
    tok_t  tok;

    btt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .q_full     (q_full),
        .push       (push),
        .push_beat  (push_beat)
    );

    btt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .full      (q_full),
        .pop       (pop),
        .pop_beat  (pop_beat),
        .empty     (q_empty)
    );

    btt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .beat      (pop_beat),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

    // Token fields onto their own ports
    assign kind        = tok.kind;
    assign range_start = tok.range_start;
    assign range_end   = tok.range_end;
    assign name_start  = tok.name_start;
    assign name_end    = tok.name_end;
    assign format_kind = tok.format_kind;
    assign int_digits  = tok.int_digits;
    assign frac_digits = tok.frac_digits;
    assign end_of_path = tok.end_of_path;

endmodule
